FILE: sv/dqb_pkg.sv
// Shared types and constants for the dual quaternion blend block.
// Used by dqb_front, dqb_fifo, dqb_back and dual_quat_weighted_blend.
`default_nettype none
package dqb_pkg;

  localparam int CW    = 32;  // component width
  localparam int WW    = 16;  // weight width
  localparam int AW    = 56;  // accumulator width
  localparam int TW    = 24;  // absolute weight total width
  localparam int EW    = 31;  // epsilon register width
  localparam int NCOMP = 4;
  localparam int QDEPTH = 2;

  localparam int IN_W  = 2 * NCOMP * CW + WW;
  localparam int OUT_W = 2 * NCOMP * CW;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [TW-1:0] ABSW_MAX   = {TW{1'b1}};
  localparam logic [TW-1:0] WEIGHT_ONE = TW'(16384);
  localparam logic signed [CW-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [CW-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic [EW-1:0] EPS_RESET = 31'd16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_WEIGHT  = 2'd1,
    ST_DEGENERATE = 2'd2
  } status_t;

  // One finished run, handed from the front end to the back end.
  typedef struct packed {
    logic [NCOMP-1:0][AW-1:0] real_acc;
    logic [NCOMP-1:0][AW-1:0] dual_acc;
    logic [TW-1:0]            abs_total;
    logic                     have_ref;
  } run_t;

endpackage
`default_nettype wire

FILE: sv/dqb_front.sv
// Front end: accepts influences, applies the shortest-arc sign and
// accumulates weighted sums. Depends on dqb_pkg.
`default_nettype none
module dqb_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [dqb_pkg::IN_W-1:0]   s_tdata,
  input  wire logic                       s_tlast,
  output logic                            q_push,
  output dqb_pkg::run_t                   q_data,
  input  wire logic                       q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DOT  = 5'b00100,
    F_ACC  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state;
  logic [1:0] cnt;
  logic [3:0][31:0] rin;
  logic [3:0][31:0] din;
  logic signed [15:0] w;
  logic last_q;
  logic [3:0][31:0] refr;
  logic have_ref;
  logic [3:0][55:0] racc;
  logic [3:0][55:0] dacc;
  logic [23:0] abs_total;
  logic signed [63:0] pd [4];
  logic signed [47:0] pr [4];
  logic signed [47:0] pu [4];
  logic neg;

  logic accept;
  logic signed [65:0] dsum;
  logic [15:0] w_abs;
  logic [24:0] tot_sum;
  logic [3:0][55:0] racc_next;
  logic [3:0][55:0] dacc_next;

  function automatic logic [55:0] sat_acc(input logic [55:0] acc, input logic [47:0] p,
                                          input logic n);
    logic [47:0] ps;
    logic [56:0] s;
    ps = n ? (~p + 48'd1) : p;
    s  = {acc[55], acc} + {{9{ps[47]}}, ps};
    if (s[56] != s[55]) begin
      sat_acc = s[56] ? dqb_pkg::ACC_MIN : dqb_pkg::ACC_MAX;
    end else begin
      sat_acc = s[55:0];
    end
  endfunction

  assign accept   = s_tvalid && (state == F_IDLE);
  assign s_tready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;

  assign q_data.real_acc  = racc;
  assign q_data.dual_acc  = dacc;
  assign q_data.abs_total = abs_total;
  assign q_data.have_ref  = have_ref;

  always_comb begin
    dsum = {{2{pd[0][63]}}, pd[0]} + {{2{pd[1][63]}}, pd[1]}
         + {{2{pd[2][63]}}, pd[2]} + {{2{pd[3][63]}}, pd[3]};
    w_abs   = w[15] ? (~w + 16'd1) : w;
    tot_sum = {1'b0, abs_total} + {9'b0, w_abs};
    for (int i = 0; i < 4; i++) begin
      racc_next[i] = sat_acc(racc[i], pr[i], neg);
      dacc_next[i] = sat_acc(dacc[i], pu[i], neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      cnt       <= '0;
      have_ref  <= 1'b0;
      refr      <= '0;
      racc      <= '0;
      dacc      <= '0;
      abs_total <= '0;
      neg       <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 4; i++) begin
              rin[i] <= s_tdata[32*i +: 32];
              din[i] <= s_tdata[128 + 32*i +: 32];
            end
            w      <= s_tdata[256 +: 16];
            last_q <= s_tlast;
            cnt    <= '0;
            // skip zero weight, but still close the run on last
            if (s_tdata[256 +: 16] != 16'd0) begin
              state <= F_MUL;
            end else if (s_tlast) begin
              state <= F_PUSH;
            end
          end
        end
        F_MUL: begin
          pd[cnt] <= $signed(rin[cnt]) * $signed(refr[cnt]);
          pr[cnt] <= $signed(rin[cnt]) * w;
          pu[cnt] <= $signed(din[cnt]) * w;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= F_DOT;
          end
        end
        F_DOT: begin
          neg   <= have_ref && dsum[65];
          state <= F_ACC;
        end
        F_ACC: begin
          racc <= racc_next;
          dacc <= dacc_next;
          abs_total <= tot_sum[24] ? dqb_pkg::ABSW_MAX : tot_sum[23:0];
          if (!have_ref) begin
            refr     <= rin;
            have_ref <= 1'b1;
          end
          state <= last_q ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_full) begin
            have_ref  <= 1'b0;
            refr      <= '0;
            racc      <= '0;
            dacc      <= '0;
            abs_total <= '0;
            neg       <= 1'b0;
            state     <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/dqb_fifo.sv
// Two-entry queue of finished run sums between front and back ends.
// Depends on dqb_pkg.
`default_nettype none
module dqb_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  dqb_pkg::run_t      wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output dqb_pkg::run_t      rdata
);

  dqb_pkg::run_t mem [dqb_pkg::QDEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(dqb_pkg::QDEPTH));
  assign valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/dqb_back.sv
// Back end: norm test, square root, normalizing divides and dual-part
// projection for one run at a time, with the output register. Depends on dqb_pkg.
`default_nettype none
module dqb_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dqb_pkg::EW-1:0]      eps,
  input  wire logic                        q_valid,
  input  dqb_pkg::run_t                    q_data,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [dqb_pkg::OUT_W-1:0]        m_tdata,
  output logic [1:0]                       m_tuser
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_TMUL = 9'b000000010,
    B_TSQ  = 9'b000000100,
    B_SQ   = 9'b000001000,
    B_SQRT = 9'b000010000,
    B_DIV  = 9'b000100000,
    B_DOT  = 9'b001000000,
    B_PROJ = 9'b010000000,
    B_DONE = 9'b100000000
  } bstate_t;

  bstate_t state;
  dqb_pkg::run_t ent;
  logic [6:0] cnt;
  logic [2:0] idx;
  logic [55:0] mul_a;
  logic [111:0] mul_b;
  logic [111:0] mul_p;
  logic [111:0] tsq;
  logic [112:0] sq;
  logic [113:0] rad;
  logic [59:0] srem;
  logic [56:0] root;
  logic [56:0] nrm;
  logic [86:0] num;
  logic [59:0] drem;
  logic [34:0] quo;
  logic qovf;
  logic dneg;
  logic signed [31:0] res_r [4];
  logic signed [31:0] res_d [4];
  logic signed [31:0] fin_d [4];
  logic signed [63:0] prod;
  logic signed [65:0] prod2;
  logic signed [35:0] dotacc;
  logic signed [33:0] dot;
  dqb_pkg::status_t status_q;
  logic [dqb_pkg::OUT_W-1:0] out_data;
  logic [1:0] out_status;
  logic out_valid;

  logic [111:0] mul_p_next;
  logic [112:0] sq_next;
  logic [61:0] s_rs;
  logic [61:0] s_trial;
  logic [61:0] s_diff;
  logic s_ge;
  logic [59:0] srem_next;
  logic [56:0] root_next;
  logic [60:0] d_rs;
  logic [60:0] d_diff;
  logic d_ge;
  logic [59:0] drem_next;
  logic [34:0] quo_next;
  logic qovf_next;
  logic [34:0] qm;
  logic [34:0] qh;
  logic signed [31:0] div_res;
  logic [2:0] load_idx;
  logic [55:0] load_x;
  logic [23:0] wmax;
  logic [1:0] ci;
  logic [1:0] pj;
  logic signed [35:0] dotacc_next;
  logic signed [33:0] dot_sat;
  logic signed [37:0] pdiff;
  logic signed [31:0] pdiff_sat;
  logic out_load;

  function automatic logic [55:0] mag56(input logic [55:0] a);
    mag56 = a[55] ? (~a + 56'd1) : a;
  endfunction

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;
  assign out_load = (state == B_DONE) && (!out_valid || m_tready);

  always_comb begin
    mul_p_next = mul_p + (mul_a[0] ? mul_b : 112'd0);
    sq_next    = sq + {1'b0, mul_p_next};

    s_rs      = {srem, rad[113:112]};
    s_trial   = {3'b0, root, 2'b01};
    s_ge      = (s_rs >= s_trial);
    s_diff    = s_rs - s_trial;
    srem_next = s_ge ? s_diff[59:0] : s_rs[59:0];
    root_next = {root[55:0], s_ge};

    d_rs      = {drem, num[86]};
    d_ge      = (d_rs >= {4'b0, nrm});
    d_diff    = d_rs - {4'b0, nrm};
    drem_next = d_ge ? d_diff[59:0] : d_rs[59:0];
    quo_next  = {quo[33:0], d_ge};
    qovf_next = qovf | quo[34];
    qm = (qovf_next || quo_next > 35'h4_0000_0000) ? 35'h4_0000_0000 : quo_next;
    qh = (qm + 35'd1) >> 1;
    if (dneg) begin
      div_res = (qh > 35'h0_8000_0000) ? dqb_pkg::S32_MIN : $signed(~qh[31:0] + 32'd1);
    end else begin
      div_res = (qh > 35'h0_7FFF_FFFF) ? dqb_pkg::S32_MAX : $signed(qh[31:0]);
    end

    load_idx = (state == B_SQRT) ? 3'd0 : idx + 3'd1;
    load_x   = load_idx[2] ? ent.dual_acc[load_idx[1:0]] : ent.real_acc[load_idx[1:0]];

    wmax = (q_data.abs_total > dqb_pkg::WEIGHT_ONE) ? q_data.abs_total : dqb_pkg::WEIGHT_ONE;

    ci = cnt[1:0];
    pj = cnt[1:0] - 2'd1;
    dotacc_next = dotacc + {{2{prod[63]}}, prod[63:30]};
    if (dotacc_next > 36'sd4294967295) begin
      dot_sat = 34'sd4294967295;
    end else if (dotacc_next < -36'sd4294967295) begin
      dot_sat = -34'sd4294967295;
    end else begin
      dot_sat = dotacc_next[33:0];
    end
    pdiff = {{6{res_d[pj][31]}}, res_d[pj]} - {{2{prod2[65]}}, prod2[65:30]};
    if (pdiff > 38'sd2147483647) begin
      pdiff_sat = dqb_pkg::S32_MAX;
    end else if (pdiff < -38'sd2147483648) begin
      pdiff_sat = dqb_pkg::S32_MIN;
    end else begin
      pdiff_sat = pdiff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      cnt        <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
      out_status <= dqb_pkg::ST_OK;
      out_data   <= '0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            ent <= q_data;
            for (int i = 0; i < 4; i++) begin
              res_r[i] <= (i == 0) ? dqb_pkg::ONE_Q30 : 32'sd0;
              fin_d[i] <= 32'sd0;
            end
            if (!q_data.have_ref) begin
              status_q <= dqb_pkg::ST_NO_WEIGHT;
              state    <= B_DONE;
            end else begin
              mul_a <= {25'b0, eps};
              mul_b <= {88'b0, wmax};
              mul_p <= '0;
              cnt   <= '0;
              state <= B_TMUL;
            end
          end
        end
        B_TMUL, B_TSQ, B_SQ: begin
          mul_p <= mul_p_next;
          mul_a <= mul_a >> 1;
          mul_b <= mul_b << 1;
          cnt   <= cnt + 7'd1;
          if (cnt == 7'd55) begin
            cnt   <= '0;
            mul_p <= '0;
            if (state == B_TMUL) begin
              mul_a <= mul_p_next[55:0];
              mul_b <= {56'b0, mul_p_next[55:0]};
              state <= B_TSQ;
            end else if (state == B_TSQ) begin
              tsq   <= mul_p_next;
              sq    <= '0;
              idx   <= '0;
              mul_a <= mag56(ent.real_acc[0]);
              mul_b <= {56'b0, mag56(ent.real_acc[0])};
              state <= B_SQ;
            end else begin
              sq <= sq_next;
              if (idx == 3'd3) begin
                if ({1'b0, tsq} >= sq_next) begin
                  status_q <= dqb_pkg::ST_DEGENERATE;
                  state    <= B_DONE;
                end else begin
                  rad   <= {1'b0, sq_next};
                  srem  <= '0;
                  root  <= '0;
                  state <= B_SQRT;
                end
              end else begin
                idx   <= idx + 3'd1;
                mul_a <= mag56(ent.real_acc[idx[1:0] + 2'd1]);
                mul_b <= {56'b0, mag56(ent.real_acc[idx[1:0] + 2'd1])};
              end
            end
          end
        end
        B_SQRT: begin
          rad  <= rad << 2;
          srem <= srem_next;
          root <= root_next;
          cnt  <= cnt + 7'd1;
          if (cnt == 7'd56) begin
            nrm   <= (root_next == 57'd0) ? 57'd1 : root_next;
            idx   <= '0;
            cnt   <= '0;
            num   <= {mag56(load_x), 31'b0};
            dneg  <= load_x[55];
            drem  <= '0;
            quo   <= '0;
            qovf  <= 1'b0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          num  <= num << 1;
          drem <= drem_next;
          quo  <= quo_next;
          qovf <= qovf_next;
          cnt  <= cnt + 7'd1;
          if (cnt == 7'd86) begin
            if (idx[2]) begin
              res_d[idx[1:0]] <= div_res;
            end else begin
              res_r[idx[1:0]] <= div_res;
            end
            cnt <= '0;
            if (idx == 3'd7) begin
              dotacc <= '0;
              state  <= B_DOT;
            end else begin
              idx  <= load_idx;
              num  <= {mag56(load_x), 31'b0};
              dneg <= load_x[55];
              drem <= '0;
              quo  <= '0;
              qovf <= 1'b0;
            end
          end
        end
        B_DOT: begin
          if (cnt != 7'd4) begin
            prod <= res_r[ci] * res_d[ci];
          end
          if (cnt != 7'd0) begin
            dotacc <= dotacc_next;
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd4) begin
            dot   <= dot_sat;
            cnt   <= '0;
            state <= B_PROJ;
          end
        end
        B_PROJ: begin
          if (cnt != 7'd4) begin
            prod2 <= res_r[ci] * dot;
          end
          if (cnt != 7'd0) begin
            fin_d[pj] <= pdiff_sat;
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd4) begin
            status_q <= dqb_pkg::ST_OK;
            cnt      <= '0;
            state    <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_load) begin
            for (int i = 0; i < 4; i++) begin
              out_data[32*i +: 32]       <= res_r[i];
              out_data[128 + 32*i +: 32] <= fin_d[i];
            end
            out_status <= status_q;
            out_valid  <= 1'b1;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/dual_quat_weighted_blend.sv
// Weighted dual quaternion blend: top level with the epsilon register.
// Instantiates dqb_front, dqb_fifo and dqb_back; depends on dqb_pkg.
//
// Usage: influences arrive on s_t* one per transaction, the run closed by
// s_tlast. tdata holds real_w..real_z (Q2.30), dual_w..dual_z (Q16.16) and
// weight (Q2.14). At the end of each run one result leaves on m_t*:
// normalized real part, projected dual part, and status in m_tuser.
// An influence of nonzero weight passes through the front end in steps
// (capture, four products, one per component, sign, accumulate); a zero
// weight is only captured. The back end works through each run with six
// bit-serial multiplies for the threshold and the norm, a square root and
// eight restoring divides, then the projection. A two-entry queue of run
// sums sits between the two, so the front end keeps taking influences
// while the back end works.
// Reset clears the run state, the queue and the output register, and sets
// norm_epsilon to 16. When m_tready is low the result holds in the output
// register, the back end waits, and the front end stalls only once the
// queue is full.
`default_nettype none
module dual_quat_weighted_blend (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // real_w, real_x, real_y, real_z, dual_w, dual_x, dual_y, dual_z, weight
  input  wire logic [dqb_pkg::IN_W-1:0]      s_tdata,
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_real_w..out_real_z, out_dual_w..out_dual_z
  output logic [dqb_pkg::OUT_W-1:0]          m_tdata,
  // status
  output logic [1:0]                         m_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [dqb_pkg::EW-1:0]        cfg_wdata
);

  logic [dqb_pkg::EW-1:0] norm_epsilon;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  dqb_pkg::run_t q_wdata;
  dqb_pkg::run_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_epsilon <= dqb_pkg::EPS_RESET;
    end else if (cfg_we) begin
      norm_epsilon <= cfg_wdata;
    end
  end

  dqb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  dqb_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  dqb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .eps      (norm_epsilon),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("run pushed into full queue");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("run popped from empty queue");

  a_error_identity: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != dqb_pkg::ST_OK) |->
      (m_tdata[dqb_pkg::OUT_W-1:32] == '0 && m_tdata[31:0] == dqb_pkg::ONE_Q30))
    else $error("error result without identity payload");

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for dual_quat_weighted_blend: random and directed blend
// runs, an in-bench blend predictor and a result scoreboard. Needs dqb_pkg.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIMIT_CYCLES = 4000000;
  localparam longint ACC_HI = 64'sd36028797018963967;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -S32_HI - 1;
  localparam longint DOT_LIM = 64'sd4294967295;
  localparam longint ABS_HI = 64'sd16777215;
  localparam logic [dqb_pkg::EW-1:0] EPS_MAX = {dqb_pkg::EW{1'b1}};

  // fields from the lowest bit up: real w..z, dual w..z, weight
  typedef struct packed {
    logic        lst;
    logic [15:0] wt;
    logic [3:0][31:0] du;
    logic [3:0][31:0] re;
  } influence_t;

  typedef struct packed {
    dqb_pkg::status_t st;
    logic [3:0][31:0] du;
    logic [3:0][31:0] re;
  } blend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [dqb_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [dqb_pkg::OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [dqb_pkg::EW-1:0] cfg_wdata = '0;

  dual_quat_weighted_blend dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  influence_t pending[$];
  blend_t     blends_due[$];
  int         idle_pct = 31;
  int         mismatches = 0;
  longint     cycles = 0;

  // predictor state
  longint      eps_q30 = 16;
  longint      ref_re[4];
  bit          have_ref = 1'b0;
  longint      re_sum[4];
  longint      du_sum[4];
  longint      abs_wsum = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // x * 2^30 / n, rounded half away from zero, saturated to 32 bits
  function automatic longint scale_div(longint x, logic [127:0] n);
    logic [127:0] mag;
    logic [127:0] q;
    longint v;
    mag = x < 0 ? 128'(-x) : 128'(x);
    q = (mag << 31) / n;
    if (q > (128'd1 << 34)) q = 128'd1 << 34;
    q = (q + 1) >> 1;
    v = x < 0 ? -longint'(q) : longint'(q);
    return clamp(v, S32_LO, S32_HI);
  endfunction

  task automatic clear_run();
    for (int i = 0; i < 4; i++) begin
      ref_re[i] = 0;
      re_sum[i] = 0;
      du_sum[i] = 0;
    end
    have_ref = 1'b0;
    abs_wsum = 0;
  endtask

  task automatic blend_step(influence_t it);
    longint rv[4], dv[4], r[4], d[4];
    longint w, sw, dotp, mw;
    logic signed [127:0] sdot;
    logic [127:0] sq, tt, nrm, c, mg;
    blend_t res;
    for (int i = 0; i < 4; i++) begin
      rv[i] = longint'($signed(it.re[i]));
      dv[i] = longint'($signed(it.du[i]));
    end
    w = longint'($signed(it.wt));
    if (w != 0) begin
      sw = w;
      if (!have_ref) begin
        for (int i = 0; i < 4; i++) ref_re[i] = rv[i];
        have_ref = 1'b1;
      end else begin
        sdot = 0;
        for (int i = 0; i < 4; i++) sdot += 128'(rv[i] * ref_re[i]);
        if (sdot < 0) sw = -w;
      end
      for (int i = 0; i < 4; i++) begin
        re_sum[i] = clamp(re_sum[i] + rv[i] * sw, ACC_LO, ACC_HI);
        du_sum[i] = clamp(du_sum[i] + dv[i] * sw, ACC_LO, ACC_HI);
      end
      abs_wsum = clamp(abs_wsum + (w < 0 ? -w : w), 0, ABS_HI);
    end
    if (!it.lst) return;
    res = '0;
    res.re[0] = dqb_pkg::ONE_Q30;
    res.st = dqb_pkg::ST_OK;
    if (!have_ref) begin
      res.st = dqb_pkg::ST_NO_WEIGHT;
    end else begin
      mw = abs_wsum > 16384 ? abs_wsum : 16384;
      tt = 128'(eps_q30) * 128'(mw);
      tt = tt * tt;
      sq = 0;
      for (int i = 0; i < 4; i++) begin
        mg = re_sum[i] < 0 ? 128'(-re_sum[i]) : 128'(re_sum[i]);
        sq += mg * mg;
      end
      if (tt >= sq) begin
        res.st = dqb_pkg::ST_DEGENERATE;
      end else begin
        nrm = 0;
        for (int b = 57; b >= 0; b--) begin
          c = nrm | (128'd1 << b);
          if (c * c <= sq) nrm = c;
        end
        if (nrm == 0) nrm = 1;
        dotp = 0;
        for (int i = 0; i < 4; i++) begin
          r[i] = scale_div(re_sum[i], nrm);
          d[i] = scale_div(du_sum[i], nrm);
          dotp += (r[i] * d[i]) >>> 30;
        end
        dotp = clamp(dotp, -DOT_LIM, DOT_LIM);
        for (int i = 0; i < 4; i++) begin
          res.re[i] = r[i][31:0];
          res.du[i] = 32'(clamp(d[i] - ((r[i] * dotp) >>> 30), S32_LO, S32_HI));
        end
      end
    end
    blends_due.push_back(res);
    clear_run();
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
  endtask

  // driver: advance to the next influence once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) blend_step({s_tlast, s_tdata});
      if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        {s_tlast, s_tdata} <= pending.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    blend_t got, want;
    cycles <= cycles + 1;
    if (!rst) m_tready <= $urandom_range(99) >= idle_pct;
    if (!rst && m_tvalid && m_tready) begin
      got = {dqb_pkg::status_t'(m_tuser), m_tdata};
      if (blends_due.size() == 0) begin
        flag_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = blends_due.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.re[i] !== want.re[i]) flag_mismatch($sformatf("real[%0d]", i), got.re[i],
                                                       want.re[i]);
          if (got.du[i] !== want.du[i]) flag_mismatch($sformatf("dual[%0d]", i), got.du[i],
                                                       want.du[i]);
        end
        if (got.st !== want.st) flag_mismatch("status", 32'(got.st), 32'(want.st));
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** dual_quat_weighted_blend: FAILED **");
      $finish;
    end
  end

  function automatic influence_t make_infl(logic [31:0] v, logic [31:0] dv,
                                           logic [15:0] w, logic l);
    influence_t it;
    for (int i = 0; i < 4; i++) begin
      it.re[i] = v;
      it.du[i] = dv;
    end
    it.wt = w;
    it.lst = l;
    return it;
  endfunction

  // queue a run; coherent: near one base rotation, with flips; zero weights too
  task automatic queue_run(int len, bit coherent);
    influence_t it;
    logic [31:0] base[4];
    int noise;
    noise = 1 << $urandom_range(30, 4);
    for (int i = 0; i < 4; i++) base[i] = $urandom_range(32'h4000_0000) - 32'h2000_0000;
    for (int k = 0; k < len; k++) begin
      for (int i = 0; i < 4; i++) begin
        it.re[i] = coherent ? base[i] + $urandom_range(noise) - noise / 2 : $urandom;
        it.du[i] = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000)
                   - 32'h0100_0000;
      end
      if (coherent && $urandom_range(3) == 0)
        for (int i = 0; i < 4; i++) it.re[i] = -it.re[i];
      case ($urandom_range(9))
        0:       it.wt = '0;
        1:       it.wt = 16'($urandom);
        2:       it.wt = 16'(-$urandom_range(16384));
        default: it.wt = 16'($urandom_range(16384, 1));
      endcase
      it.lst = k == len - 1;
      pending.push_back(it);
    end
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !s_tvalid && blends_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_epsilon(logic [dqb_pkg::EW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_q30 = longint'(v);
  endtask

  task automatic random_phase(int items);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < items) begin
      len = $urandom_range(9) == 0 ? $urandom_range(40, 9) : $urandom_range(8, 1);
      queue_run(len, $urandom_range(9) < 7);
      cnt += len;
    end
    drain();
  endtask

  initial begin
    clear_run();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_epsilon(dqb_pkg::EPS_RESET);

    // directed: unit rotation, all-zero run, shortest-arc flip with zero-weight
    // last, field extremes, degenerate norm, dual extremes
    pending.push_back(make_infl(32'h0, 32'h0001_0000, 16'sd16384, 1'b0));
    pending.push_back(make_infl(32'h2000_0000, 32'h0, 16'sd16384, 1'b1));
    pending.push_back(make_infl(32'h7FFF_FFFF, 32'h1234_5678, 16'h0, 1'b0));
    pending.push_back(make_infl(32'h8000_0000, 32'h8000_0000, 16'h0, 1'b1));
    pending.push_back(make_infl(32'h2000_0000, 32'h0010_0000, 16'h7FFF, 1'b0));
    pending.push_back(make_infl(32'hE000_0000, 32'hFFF0_0000, 16'h8000, 1'b0));
    pending.push_back(make_infl(32'h1000_0000, 32'h0, 16'h4000, 1'b0));
    pending.push_back(make_infl(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 1'b1));
    pending.push_back(make_infl(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b1));
    pending.push_back(make_infl(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b1));
    pending.push_back(make_infl(32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 1'b1));
    pending.push_back(make_infl(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1));
    pending.push_back(make_infl(32'h4000_0000, 32'h0000_0001, 16'hFFFF, 1'b0));
    pending.push_back(make_infl(32'hC000_0000, 32'hFFFF_FFFF, 16'h0001, 1'b1));
    drain();

    // overlong run: the absolute weight total saturates
    for (int k = 0; k < 600; k++)
      pending.push_back(make_infl(k[0] ? 32'h7FFF_FFFF : 32'h7FFF_FFF0,
                                  32'h8000_0000, k[1] ? 16'h7FFF : 16'h8001, k == 599));
    drain();

    random_phase(700);
    set_epsilon('0);
    random_phase(250);
    set_epsilon(EPS_MAX);
    random_phase(100);
    set_epsilon(dqb_pkg::EW'($urandom));
    idle_pct = 0;
    random_phase(250);
    idle_pct = 31;
    set_epsilon(dqb_pkg::EW'($urandom_range(1 << 20)));
    random_phase(300);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && blends_due.size() == 0) begin
      $display("** dual_quat_weighted_blend: PASSED **");
    end else begin
      $display("** dual_quat_weighted_blend: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: dual_quat_weighted_blend.f
sv/dqb_pkg.sv
sv/dqb_front.sv
sv/dqb_fifo.sv
sv/dqb_back.sv
sv/dual_quat_weighted_blend.sv
verif/tb.sv
